// File: src/rlpf_pkg.sv
// Shared types, widths and tables of the resonant low-pass filter.
package rlpf_pkg;

  localparam int SampleW   = 20;
  localparam int CutoffW   = 13;
  localparam int ExpW      = 4;
  localparam int MantW     = 10;
  localparam int SelW      = 5;
  localparam int CfgDataW  = 5;
  localparam int ResW      = 13;
  localparam int ResMagW   = 12;
  localparam int TaW       = 40;
  localparam int F0W       = 30;
  localparam int FW        = 31;
  localparam int CoefW     = 33;
  localparam int FracW     = 30;
  localparam int SumW      = 54;
  localparam int CoefSteps = 12;
  localparam int MacSteps  = 20;
  localparam int CntW      = 5;

  // Register indexes of the configuration port
  localparam logic CfgResonance = 1'b0;
  localparam logic CfgBypass    = 1'b1;

  localparam logic signed [CoefW-1:0] Q31 = 33'sh0_8000_0000;
  localparam logic signed [CoefW-1:0] Q30 = 33'sh0_4000_0000;
  // 2^19 * (a + b - c), removed after the multipliers are offset to unsigned
  localparam logic [SumW-1:0] DcOffset = 54'h2_0000_0000_0000;

  localparam logic [SampleW-1:0] SampleMax = 20'h7FFFF;
  localparam logic [SampleW-1:0] SampleMin = 20'h80000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_FSUM,
    ST_COMB,
    ST_MAC,
    ST_SUM,
    ST_DONE
  } state_t;

  // Resonance correction, Q12 relative to the cutoff term
  function automatic logic signed [ResW-1:0] res_correction(input logic [SelW-1:0] sel);
    logic signed [ResW-1:0] res;
    case (sel)
      5'd0:    res = 13'sd2048;
      5'd1:    res = 13'sd1536;
      5'd2:    res = 13'sd1024;
      5'd3:    res = 13'sd512;
      5'd4:    res = 13'sd0;
      5'd5:    res = -13'sd256;
      5'd6:    res = -13'sd512;
      5'd7:    res = -13'sd768;
      5'd8:    res = -13'sd1024;
      5'd9:    res = -13'sd1280;
      5'd10:   res = -13'sd1536;
      5'd11:   res = -13'sd1792;
      5'd12:   res = -13'sd2048;
      5'd13:   res = -13'sd2176;
      5'd14:   res = -13'sd2304;
      5'd15:   res = -13'sd2432;
      5'd16:   res = -13'sd2560;
      5'd17:   res = -13'sd2688;
      5'd18:   res = -13'sd2816;
      5'd19:   res = -13'sd2944;
      5'd20:   res = -13'sd3072;
      5'd21:   res = -13'sd3136;
      5'd22:   res = -13'sd3200;
      5'd23:   res = -13'sd3264;
      5'd24:   res = -13'sd3328;
      5'd25:   res = -13'sd3392;
      5'd26:   res = -13'sd3456;
      5'd27:   res = -13'sd3520;
      5'd28:   res = -13'sd3584;
      5'd29:   res = -13'sd3648;
      5'd30:   res = -13'sd3712;
      default: res = -13'sd3776;
    endcase
    return res;
  endfunction

endpackage

// File: src/resonant_lowpass_filter.sv
// Resonant second-order low-pass filter with bit-serial coefficient and tap arithmetic.
//
//   channel  | signals                                   | role
//   ---------+-------------------------------------------+--------------------------
//   cfg      | cfg_we, cfg_index, cfg_data               | register write, no wait
//   in       | in_valid, in_ready, sample_in, cutoff     | sample request
//   out      | out_valid, out_ready, sample_out          | filtered sample request
//
// A filtered sample passes from acceptance to the next acceptance through 12 steps of
// the bit-serial coefficient multipliers, the coefficient add states FSUM and COMB, 20
// steps of the bit-serial tap accumulator, the sum state, the result state and the idle
// state that takes the next request.
// With bypass set a request is passed straight to the output register.
// Synchronous reset clears the filter state, sets bypass and leaves the block idle.
// A stalled output holds the finished result; the next request is taken meanwhile
// and waits in its result state until the output register frees up.
module resonant_lowpass_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [rlpf_pkg::CfgDataW-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rlpf_pkg::SampleW-1:0]  sample_in,
  input  logic [rlpf_pkg::CutoffW-1:0]         cutoff,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rlpf_pkg::SampleW-1:0]  sample_out
);

  rlpf_pkg::state_t state, state_next;

  logic [rlpf_pkg::SelW-1:0]           resonance_select;
  logic                                bypass;
  logic signed [rlpf_pkg::SampleW-1:0] previous_output;
  logic signed [rlpf_pkg::SampleW-1:0] older_output;
  // Remainder magnitude: the carried fraction is the negation of this
  logic [rlpf_pkg::FracW-1:0]          fraction_carry;
  logic [rlpf_pkg::CntW-1:0]           cnt;

  logic                                accept;
  logic                                out_free;
  logic                                done_load;
  logic                                bypass_load;

  // Decode of the incoming request
  logic [rlpf_pkg::ExpW-1:0]           expo;
  logic [rlpf_pkg::MantW-1:0]          mant;
  logic [rlpf_pkg::MantW-1:0]          mant_m1;
  logic [rlpf_pkg::TaW-1:0]            ta_init;
  logic [rlpf_pkg::F0W-1:0]            f0_init;
  logic signed [rlpf_pkg::ResW-1:0]    res_val;
  logic [rlpf_pkg::ResW-1:0]           res_abs;

  // Held request and coefficient multipliers
  logic signed [rlpf_pkg::SampleW-1:0] x_hold;
  logic                                exp_zero;
  logic                                res_neg;
  logic [rlpf_pkg::TaW-1:0]            ta;
  logic [rlpf_pkg::TaW-1:0]            acc_a;
  logic [rlpf_pkg::ResMagW-1:0]        lo_a;
  logic [rlpf_pkg::F0W-1:0]            f0;
  logic [rlpf_pkg::F0W-1:0]            acc_r;
  logic [rlpf_pkg::ResMagW-1:0]        lo_r;
  logic [rlpf_pkg::TaW:0]              sum_a;
  logic [rlpf_pkg::F0W:0]              sum_r;

  logic [rlpf_pkg::FW-1:0]             f;
  logic signed [rlpf_pkg::CoefW-1:0]   a33;
  logic signed [rlpf_pkg::CoefW-1:0]   f33;
  logic signed [rlpf_pkg::CoefW-1:0]   na;
  logic signed [rlpf_pkg::CoefW-1:0]   am;

  // Tap multiplicands: the sums of a, b and -c that one multiplier bit column selects; all three is Q30
  logic signed [rlpf_pkg::CoefW-1:0]   mc_a, mc_b, mc_nc, mc_ab, mc_an, mc_bn;
  logic signed [rlpf_pkg::CoefW-1:0]   term;
  logic signed [rlpf_pkg::CoefW-1:0]   mac_hi;
  logic [rlpf_pkg::CoefW:0]            mac_sum;
  logic [rlpf_pkg::SampleW-1:0]        mac_lo;
  logic [rlpf_pkg::SampleW-1:0]        y1_sh;
  logic [rlpf_pkg::SampleW-1:0]        y2_sh;

  logic [rlpf_pkg::FracW-1:0]          frac_use;
  logic [rlpf_pkg::SumW-1:0]           s_acc;
  logic [rlpf_pkg::SumW-rlpf_pkg::FracW-1:0] w;
  logic [rlpf_pkg::SampleW-1:0]        y_sat;

  // ---------------------------------------------------------------- control

  always_comb begin
    state_next = state;
    case (state)
      rlpf_pkg::ST_IDLE: if (accept && !bypass) state_next = rlpf_pkg::ST_COEF;
      rlpf_pkg::ST_COEF: if (cnt == '0) state_next = rlpf_pkg::ST_FSUM;
      rlpf_pkg::ST_FSUM: state_next = rlpf_pkg::ST_COMB;
      rlpf_pkg::ST_COMB: state_next = rlpf_pkg::ST_MAC;
      rlpf_pkg::ST_MAC:  if (cnt == '0) state_next = rlpf_pkg::ST_SUM;
      rlpf_pkg::ST_SUM:  state_next = rlpf_pkg::ST_DONE;
      rlpf_pkg::ST_DONE: if (out_free) state_next = rlpf_pkg::ST_IDLE;
      default:           state_next = rlpf_pkg::ST_IDLE;
    endcase
  end

  assign out_free    = !out_valid || out_ready;
  assign accept      = in_valid && in_ready;
  assign bypass_load = accept && bypass;

  always_comb begin
    in_ready  = 1'b0;
    done_load = 1'b0;
    case (state)
      rlpf_pkg::ST_IDLE: in_ready  = !bypass || out_free;
      rlpf_pkg::ST_DONE: done_load = out_free;
      default: begin
        in_ready  = 1'b0;
        done_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= rlpf_pkg::ST_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      resonance_select <= '0;
      bypass           <= 1'b1;
      previous_output  <= '0;
      older_output     <= '0;
      fraction_carry   <= '0;
    end else begin
      state <= state_next;

      if (accept) begin
        cnt <= rlpf_pkg::CntW'(rlpf_pkg::CoefSteps - 1);
      end else if (state == rlpf_pkg::ST_COMB) begin
        cnt <= rlpf_pkg::CntW'(rlpf_pkg::MacSteps - 1);
      end else if (state == rlpf_pkg::ST_COEF || state == rlpf_pkg::ST_MAC) begin
        cnt <= cnt - 1'b1;
      end

      if (bypass_load || done_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          rlpf_pkg::CfgResonance: resonance_select <= cfg_data[rlpf_pkg::SelW-1:0];
          rlpf_pkg::CfgBypass:    bypass           <= cfg_data[0];
          default: ;
        endcase
      end

      if (done_load) begin
        older_output    <= previous_output;
        previous_output <= y_sat;
        fraction_carry  <= s_acc[rlpf_pkg::FracW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- request decode

  always_comb begin
    expo    = cutoff[rlpf_pkg::CutoffW-1 -: rlpf_pkg::ExpW];
    mant    = {1'b1, cutoff[rlpf_pkg::MantW-2:0]};
    mant_m1 = mant - 1'b1;
    ta_init = {mant, {(rlpf_pkg::TaW - rlpf_pkg::MantW){1'b0}}} >> {4'd15 - expo, 1'b0};
    f0_init = {{(rlpf_pkg::F0W - rlpf_pkg::MantW - 5){1'b0}}, mant, 5'd0} << expo;
    res_val = rlpf_pkg::res_correction(resonance_select);
    res_abs = res_val[rlpf_pkg::ResW-1] ? rlpf_pkg::ResW'(-res_val) : res_val;
  end

  // ---------------------------------------------------------------- datapath

  assign sum_a = {1'b0, acc_a} + (lo_a[0] ? {1'b0, ta} : '0);
  assign sum_r = {1'b0, acc_r} + (lo_r[0] ? {1'b0, f0} : '0);

  // a = (ta * k) >> 17 sits in bits 34..5 of the high half
  assign a33 = $signed({3'b000, acc_a[34:5]});
  assign f33 = $signed({2'b00, f});

  always_comb begin
    case ({mac_lo[0], y1_sh[0], y2_sh[0]})
      3'b100:  term = mc_a;
      3'b010:  term = mc_b;
      3'b001:  term = mc_nc;
      3'b110:  term = mc_ab;
      3'b101:  term = mc_an;
      3'b011:  term = mc_bn;
      3'b111:  term = rlpf_pkg::Q30;
      default: term = '0;
    endcase
  end

  assign mac_sum  = {mac_hi[rlpf_pkg::CoefW-1], mac_hi} + {term[rlpf_pkg::CoefW-1], term};
  assign frac_use = exp_zero ? '0 : fraction_carry;

  assign w = s_acc[rlpf_pkg::SumW-1:rlpf_pkg::FracW];

  always_comb begin
    // Clamp unless the top bits of the quotient are all sign
    if (&w[rlpf_pkg::SumW-rlpf_pkg::FracW-1:rlpf_pkg::SampleW-1] ||
        ~|w[rlpf_pkg::SumW-rlpf_pkg::FracW-1:rlpf_pkg::SampleW-1]) begin
      y_sat = w[rlpf_pkg::SampleW-1:0];
    end else if (w[rlpf_pkg::SumW-rlpf_pkg::FracW-1]) begin
      y_sat = rlpf_pkg::SampleMin;
    end else begin
      y_sat = rlpf_pkg::SampleMax;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_hold   <= sample_in;
      exp_zero <= (expo == '0);
      res_neg  <= res_val[rlpf_pkg::ResW-1];
      ta       <= ta_init;
      f0       <= f0_init;
      acc_a    <= '0;
      acc_r    <= '0;
      lo_a     <= {{(rlpf_pkg::ResMagW - 7){1'b0}}, mant_m1[rlpf_pkg::MantW-1:3]};
      lo_r     <= res_abs[rlpf_pkg::ResMagW-1:0];
    end

    // Shift-add one multiplier bit per cycle; product bits move into the low half
    if (state == rlpf_pkg::ST_COEF) begin
      acc_a <= sum_a[rlpf_pkg::TaW:1];
      lo_a  <= {sum_a[0], lo_a[rlpf_pkg::ResMagW-1:1]};
      acc_r <= sum_r[rlpf_pkg::F0W:1];
      lo_r  <= {sum_r[0], lo_r[rlpf_pkg::ResMagW-1:1]};
    end

    if (state == rlpf_pkg::ST_FSUM) begin
      f  <= res_neg ? {1'b0, f0} - {1'b0, acc_r} : {1'b0, f0} + {1'b0, acc_r};
      na <= rlpf_pkg::Q31 - a33;
      am <= a33 - rlpf_pkg::Q30;
    end

    if (state == rlpf_pkg::ST_COMB) begin
      mc_a   <= a33;
      mc_b   <= na - f33;
      mc_nc  <= f33 - rlpf_pkg::Q30;
      mc_ab  <= rlpf_pkg::Q31 - f33;
      mc_an  <= f33 + am;
      mc_bn  <= na - rlpf_pkg::Q30;
      mac_hi <= '0;
      // Flip the sign bits: each multiplier becomes its value plus 2^19
      mac_lo <= {~x_hold[rlpf_pkg::SampleW-1], x_hold[rlpf_pkg::SampleW-2:0]};
      y1_sh  <= {~previous_output[rlpf_pkg::SampleW-1],
                 previous_output[rlpf_pkg::SampleW-2:0]};
      y2_sh  <= {~older_output[rlpf_pkg::SampleW-1], older_output[rlpf_pkg::SampleW-2:0]};
    end

    if (state == rlpf_pkg::ST_MAC) begin
      mac_hi <= mac_sum[rlpf_pkg::CoefW:1];
      mac_lo <= {mac_sum[0], mac_lo[rlpf_pkg::SampleW-1:1]};
      y1_sh  <= y1_sh >> 1;
      y2_sh  <= y2_sh >> 1;
    end

    if (state == rlpf_pkg::ST_SUM) begin
      s_acc <= {mac_hi[rlpf_pkg::CoefW-1], mac_hi, mac_lo}
             + {{(rlpf_pkg::SumW - rlpf_pkg::FracW){1'b0}}, frac_use}
             - rlpf_pkg::DcOffset;
    end

    if (bypass_load) begin
      sample_out <= sample_in;
    end else if (done_load) begin
      sample_out <= y_sat;
    end
  end

  // ---------------------------------------------------------------- assertions

  a_filtered_result_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !bypass) |-> ##37 out_valid)
    else $error("filtered result not presented in time");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    (state == rlpf_pkg::ST_DONE && out_free) |=>
      (out_valid && sample_out == previous_output))
    else $error("output and stored previous output disagree");

  a_bypass_holds_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && bypass) |=>
      (out_valid && sample_out == $past(sample_in) && $stable(previous_output)
       && $stable(fraction_carry)))
    else $error("bypass request altered filter state or output");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the resonant low-pass filter.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [rlpf_pkg::SampleW-1:0] sample;
    logic [rlpf_pkg::CutoffW-1:0] cutoff;
  } filt_req_t;

  localparam longint Q30One = 64'sd1 << 30;
  localparam longint OutMax = 524287;
  localparam longint OutMin = -524288;
  localparam int DrainCycles = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = rlpf_pkg::CfgResonance;
  logic [rlpf_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [rlpf_pkg::SampleW-1:0] sample_in = '0;
  logic [rlpf_pkg::CutoffW-1:0] cutoff = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [rlpf_pkg::SampleW-1:0] sample_out;

  resonant_lowpass_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .cutoff    (cutoff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the registers and the filter state
  int     res_sel = 0;
  logic   bypass_on = 1'b1;
  longint y_prev = 0;
  longint y_older = 0;
  longint frac_rem = 0;

  filt_req_t                    sample_requests[$];
  logic [rlpf_pkg::SampleW-1:0] expected_samples[$];
  int                           mismatches = 0;

  function automatic longint resonance_gain(input int sel);
    if (sel <= 4) return longint'(2048 - 512 * sel);
    else if (sel <= 12) return longint'(-256 * (sel - 4));
    else if (sel <= 20) return longint'(-2048 - 128 * (sel - 12));
    else return longint'(-3072 - 64 * (sel - 20));
  endfunction

  // Advance the filter by one request and return the sample it produces
  function automatic logic [rlpf_pkg::SampleW-1:0] filter_sample(input filt_req_t req);
    longint x, ta, a, f0, f, b, c, s, w, y;
    int     expo, mant;
    x = longint'($signed(req.sample));
    if (bypass_on) return req.sample;
    expo = int'(req.cutoff[rlpf_pkg::CutoffW-1 -: rlpf_pkg::ExpW]);
    mant = int'({1'b1, req.cutoff[8:0]});
    ta = (longint'(mant) << 30) >>> ((15 - expo) * 2);
    a = (ta * ((mant - 1) / 8)) >>> 17;
    f0 = longint'(mant) << (expo + 5);
    f = f0 + (resonance_gain(res_sel) * f0) / 4096;
    b = 2 * Q30One - f - a;
    c = Q30One - f;
    if (expo == 0) frac_rem = 0;
    s = a * x + b * y_prev - c * y_older - frac_rem;
    w = s >>> 30;
    frac_rem = w * Q30One - s;
    y = w;
    if (y < OutMin) y = OutMin;
    else if (y > OutMax) y = OutMax;
    y_older = y_prev;
    y_prev = y;
    return y[rlpf_pkg::SampleW-1:0];
  endfunction

  // Sender: bursts of random length separated by random gaps
  int   burst_left = 0;
  int   gap_left = 0;
  logic req_held;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      req_held = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        expected_samples.push_back(filter_sample(sample_requests.pop_front()));
      end
      if (!req_held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_requests.size() > 0) begin
          in_valid  <= 1'b1;
          sample_in <= sample_requests[0].sample;
          cutoff    <= sample_requests[0].cutoff;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern changes with the top two bits of a free-running counter
  logic [9:0] ready_cyc = '0;
  int         stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      ready_cyc <= ready_cyc + 1'b1;
      case (ready_cyc[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 2) != 0);
        2'd2: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(10, 60);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: out_ready <= ready_cyc[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected filtered sample %0d", sample_out);
      end else if (sample_out !== expected_samples[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample_out mismatch: expected %0d, got %0d",
                   $signed(expected_samples[0]), sample_out);
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (sample_requests.size() != 0 || expected_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [rlpf_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rlpf_pkg::CfgResonance) res_sel = int'(data);
    else bypass_on = data[0];
  endtask

  task automatic queue_req(input logic [rlpf_pkg::SampleW-1:0] smp,
                           input logic [rlpf_pkg::CutoffW-1:0] cut);
    sample_requests.push_back('{sample: smp, cutoff: cut});
  endtask

  // Runs of related requests so that the recurrence settles, rings and saturates
  task automatic queue_random(input int count);
    int                           left, run_len, sig_mode, cut_mode, k;
    logic [rlpf_pkg::CutoffW-1:0] run_cut, cut;
    logic [rlpf_pkg::SampleW-1:0] run_level, smp;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(1, 60);
      if (run_len > left) run_len = left;
      sig_mode = $urandom_range(0, 4);
      cut_mode = $urandom_range(0, 3);
      run_cut = rlpf_pkg::CutoffW'($urandom);
      run_level = rlpf_pkg::SampleW'($urandom);
      for (k = 0; k < run_len; k++) begin
        case (sig_mode)
          0: smp = rlpf_pkg::SampleW'($urandom);
          1: smp = ((k % 16) < 8) ? rlpf_pkg::SampleMax : rlpf_pkg::SampleMin;
          2: smp = k[0] ? rlpf_pkg::SampleMax : rlpf_pkg::SampleMin;
          3: smp = rlpf_pkg::SampleW'($urandom_range(0, 4095) - 2048);
          default: smp = run_level;
        endcase
        case (cut_mode)
          0: cut = run_cut;
          1: cut = rlpf_pkg::CutoffW'($urandom);
          // exponent zero now and then, after the remainder has built up
          2: cut = ((k % 5) == 4) ? {4'd0, 9'($urandom)} : run_cut;
          default: cut = {4'd15, 9'($urandom)};
        endcase
        queue_req(smp, cut);
      end
      left -= run_len;
    end
  endtask

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bypass is set out of reset
    queue_req(rlpf_pkg::SampleMax, 13'd0);
    queue_req(rlpf_pkg::SampleMin, 13'd8191);
    queue_req(20'd0, 13'd4096);
    queue_req(20'hFFFFF, 13'd511);

    // upper data bits must be dropped, leaving bypass clear
    write_reg(rlpf_pkg::CfgBypass, 5'b11110);
    queue_req(rlpf_pkg::SampleMax, 13'd8191);
    queue_req(rlpf_pkg::SampleMax, 13'd8191);
    queue_req(rlpf_pkg::SampleMax, 13'd8191);
    queue_req(rlpf_pkg::SampleMin, 13'd8191);
    queue_req(rlpf_pkg::SampleMin, 13'd7680);
    queue_req(rlpf_pkg::SampleMax, 13'd7680);
    queue_req(20'd12345, 13'd4607);
    queue_req(20'd0, 13'd0);
    queue_req(rlpf_pkg::SampleMax, 13'd511);
    queue_req(20'hFFFFF, 13'd512);
    queue_req(20'd1, 13'd4096);
    queue_req(rlpf_pkg::SampleMin, 13'd0);
    queue_req(rlpf_pkg::SampleMax, 13'd3072);
    queue_req(rlpf_pkg::SampleMin, 13'd6655);
    queue_req(rlpf_pkg::SampleMax, 13'd6655);
    queue_req(20'd0, 13'd1);

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_reg(rlpf_pkg::CfgResonance, 5'd31);
        1: write_reg(rlpf_pkg::CfgResonance, 5'd0);
        5: write_reg(rlpf_pkg::CfgBypass, 5'b10101);
        6: write_reg(rlpf_pkg::CfgBypass, 5'b01010);
        default: write_reg(rlpf_pkg::CfgResonance, 5'($urandom));
      endcase
      queue_random(135);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
src/rlpf_pkg.sv
src/resonant_lowpass_filter.sv
tb/sv/tb.sv
